[hdl/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// SBUS frame decoder package
// Frame constants and shared types for the SBUS frame channel decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int STORE_DEPTH   = FRAME_BYTES - 2;
    localparam int POS_W         = 5;
    localparam int NUM_CHANS     = 12;
    localparam int CHAN_W        = 11;
    localparam int PAYLOAD_BITS  = NUM_CHANS * CHAN_W;
    localparam int PAYLOAD_BYTES = (PAYLOAD_BITS + 7) / 8;
    localparam int TDATA_W       = PAYLOAD_BYTES * 8;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE    = 8'h00;

    localparam logic [POS_W-1:0] POS_HUNT = '0;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             frame_ok;
    } sfd_status_t;

endpackage

[hdl/sfd_framer.sv]
// ----------------------------------------------------------------------------
// SBUS frame tracker
// Hunts for the header, collects payload bytes and checks the end byte.
// ----------------------------------------------------------------------------
module sfd_framer
    import sfd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    byte_valid,
    input  byte_t                   rx_byte,
    output sfd_status_t             status,
    output logic [PAYLOAD_BITS-1:0] payload
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    byte_t            store_reg [STORE_DEPTH];
    logic             collect;
    logic             frame_ok;
    logic [TDATA_W-1:0] flat;

    always_comb begin
        pos_next = pos_reg;
        collect  = 1'b0;
        frame_ok = 1'b0;
        if (byte_valid) begin
            priority if (pos_reg == POS_HUNT) begin
                if (rx_byte == HEADER_BYTE) begin
                    pos_next = POS_W'(1);
                end
            end else if (pos_reg < POS_LAST) begin
                collect  = 1'b1;
                pos_next = pos_reg + POS_W'(1);
            end else begin
                pos_next = POS_HUNT;
                frame_ok = (rx_byte == END_BYTE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // The store is a shift line, so after a full frame entry 0 holds the
    // first payload byte.
    always_ff @(posedge aclk) begin
        if (collect) begin
            for (int i = 0; i < STORE_DEPTH - 1; i++) begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[STORE_DEPTH-1] <= rx_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            flat[8*i +: 8] = store_reg[i];
        end
    end

    assign payload         = flat[PAYLOAD_BITS-1:0];
    assign status.pos      = pos_reg;
    assign status.frame_ok = frame_ok;

endmodule

[hdl/sfd_unpack.sv]
// ----------------------------------------------------------------------------
// SBUS channel unpacker
// Splits the payload into channel values and holds them in the result register.
// ----------------------------------------------------------------------------
module sfd_unpack
    import sfd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic [PAYLOAD_BITS-1:0] payload,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [TDATA_W-1:0]      out_data
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [CHAN_W-1:0]       chan_reg  [NUM_CHANS];
    logic [CHAN_W-1:0]       chan_next [NUM_CHANS];
    logic [PAYLOAD_BITS-1:0] packed_chans;

    always_comb begin
        for (int k = 0; k < NUM_CHANS; k++) begin
            chan_next[k] = payload[CHAN_W*k +: CHAN_W];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            chan_reg <= chan_next;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_CHANS; k++) begin
            packed_chans[CHAN_W*k +: CHAN_W] = chan_reg[k];
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {{(TDATA_W - PAYLOAD_BITS){1'b0}}, packed_chans};

endmodule

[hdl/sbus_frame_channel_decoder.sv]
// The result is registered: m_tvalid rises in the cycle after the end byte of a good frame is accepted.
// Throughput: one byte per cycle; s_tready drops only while a result waits on m_tready.
// A frame of 25 bytes gives at most one result; bad frames give none.
// Reset (aresetn low, synchronous) returns the decoder to header hunting and empties
// the result register; the payload store is not cleared.
// ----------------------------------------------------------------------------
// SBUS frame channel decoder
// Finds 25-byte SBUS frames in a byte stream and emits channels 1 to 12.
// ----------------------------------------------------------------------------
module sbus_frame_channel_decoder
    import sfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte[7:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // chan_0 [10:0] up to chan_11 [131:121], zero pad
);

    logic                    byte_valid;
    sfd_status_t             status;
    logic [PAYLOAD_BITS-1:0] payload;

    assign s_tready   = !m_tvalid || m_tready;
    assign byte_valid = s_tvalid && s_tready;

    sfd_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .rx_byte    (s_tdata),
        .status     (status),
        .payload    (payload)
    );

    sfd_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (status.frame_ok),
        .payload   (payload),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        status.pos <= POS_LAST)
        else $error("Frame position out of range.");

    a_ok_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        status.frame_ok |-> byte_valid && s_tdata == END_BYTE && status.pos == POS_LAST)
        else $error("Frame accepted without a valid end byte.");

    a_ok_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        status.frame_ok |=> m_tvalid && status.pos == POS_HUNT)
        else $error("Good frame did not produce a result.");

endmodule

[dv/sbus_frame_channel_decoder_tb.sv]
// ----------------------------------------------------------------------------
// SBUS frame channel decoder testbench
// Streams received bytes into the decoder and checks every channel transaction
// against a frame tracker kept inside the bench. The byte stream mixes good
// frames, frames with a bad end byte, cut-off frames and line noise. Both
// sides of the stream insert random gaps and stalls.
// ----------------------------------------------------------------------------
module sbus_frame_channel_decoder_tb
    import sfd_pkg::*;
();

    localparam int RANDOM_BYTES = 1550;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        logic  hold;
        byte_t data;
    } rx_item_t;

    typedef logic [NUM_CHANS-1:0][CHAN_W-1:0] chan_set_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    rx_item_t  rx_q[$];
    chan_set_t chan_expect_q[$];

    logic [POS_W-1:0] frame_pos = POS_HUNT;
    byte_t            payload [STORE_DEPTH];

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int cycle_cnt = 0;
    int fail_cnt = 0;
    int queued_bytes = 0;
    int bytes_sent = 0;
    int frames_good = 0;
    int frames_bad_end = 0;
    int frames_cut = 0;
    int results_seen = 0;

    sbus_frame_channel_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic int pick_gap(input bit calm);
        if (calm || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic track_rx_byte(input byte_t b);
        logic [STORE_DEPTH*8-1:0] bits;
        chan_set_t                chans;
        if (frame_pos == POS_HUNT) begin
            if (b == HEADER_BYTE) begin
                frame_pos = POS_W'(1);
            end
        end else if (frame_pos < POS_LAST) begin
            payload[frame_pos - POS_W'(1)] = b;
            frame_pos = frame_pos + POS_W'(1);
        end else begin
            frame_pos = POS_HUNT;
            if (b == END_BYTE) begin
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    bits[8*i +: 8] = payload[i];
                end
                for (int k = 0; k < NUM_CHANS; k++) begin
                    chans[k] = bits[CHAN_W*k +: CHAN_W];
                end
                chan_expect_q.push_back(chans);
                frames_good++;
            end else begin
                frames_bad_end++;
            end
        end
    endtask

    task automatic check_channels(input logic [TDATA_W-1:0] data);
        chan_set_t want;
        results_seen++;
        if (chan_expect_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
                $display("channel transaction %0d arrived with none expected: %h",
                         results_seen, data);
            end
        end else begin
            want = chan_expect_q.pop_front();
            for (int k = 0; k < NUM_CHANS; k++) begin
                if (data[CHAN_W*k +: CHAN_W] !== want[k]) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("channel transaction %0d chan_%0d: expected %0d, got %0d",
                                 results_seen, k, want[k], data[CHAN_W*k +: CHAN_W]);
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            frame_pos = POS_HUNT;
            gap_left  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_rx_byte(s_tdata);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (rx_q.size() != 0 &&
                             !(rx_q[0].hold && chan_expect_q.size() != 0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_q[0].data;
                    void'(rx_q.pop_front());
                    if ($urandom_range(0, 49) == 0) begin
                        tx_calm = !tx_calm;
                    end
                    gap_left = pick_gap(tx_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // A stall only counts down while a result is waiting, so each result sees it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_channels(m_tdata);
                if ($urandom_range(0, 29) == 0) begin
                    rx_calm = !rx_calm;
                end
                stall_left = pick_gap(rx_calm);
            end else if (m_tvalid && stall_left > 0) begin
                stall_left = stall_left - 1;
            end
            m_tready <= (stall_left == 0);
        end
    end

    task automatic push_rx(input byte_t b, input logic hold);
        rx_item_t item;
        item.hold = hold;
        item.data = b;
        rx_q.push_back(item);
        queued_bytes++;
    endtask

    task automatic add_frame(input int payload_len, input bit rand_fill, input byte_t fill,
                             input byte_t end_b, input logic hold);
        byte_t b;
        push_rx(HEADER_BYTE, hold);
        for (int i = 0; i < payload_len; i++) begin
            if (!rand_fill) begin
                b = fill;
            end else if ($urandom_range(0, 15) == 0) begin
                b = HEADER_BYTE;
            end else begin
                b = byte_t'($urandom);
            end
            push_rx(b, 1'b0);
        end
        if (payload_len == STORE_DEPTH) begin
            push_rx(end_b, 1'b0);
        end else begin
            frames_cut++;
        end
    endtask

    initial begin
        int    target;
        int    pick;
        bit    mid_hold_done;
        logic  hold;
        mid_hold_done = 1'b0;

        push_rx(8'h00, 1'b0);
        push_rx(8'hFF, 1'b0);
        push_rx(8'h0E, 1'b0);
        push_rx(8'hF0, 1'b0);
        add_frame(STORE_DEPTH, 1'b0, 8'hFF, END_BYTE, 1'b0);
        add_frame(STORE_DEPTH, 1'b0, 8'h00, END_BYTE, 1'b0);
        add_frame(STORE_DEPTH, 1'b0, HEADER_BYTE, END_BYTE, 1'b0);
        add_frame(STORE_DEPTH, 1'b0, 8'h55, END_BYTE, 1'b0);
        add_frame(STORE_DEPTH, 1'b0, 8'hAA, END_BYTE, 1'b0);
        add_frame(STORE_DEPTH, 1'b1, 8'h00, 8'hFF, 1'b0);
        add_frame(STORE_DEPTH, 1'b1, 8'h00, HEADER_BYTE, 1'b0);
        add_frame(STORE_DEPTH, 1'b1, 8'h00, END_BYTE, 1'b1);

        target = RANDOM_BYTES;
        while (queued_bytes < target) begin
            pick = $urandom_range(0, 99);
            hold = ($urandom_range(0, 39) == 0);
            if (!mid_hold_done && queued_bytes >= target - RANDOM_BYTES / 2) begin
                hold = 1'b1;
                mid_hold_done = 1'b1;
            end
            if (pick < 8) begin
                push_rx(byte_t'($urandom), 1'b0);
            end else if (pick < 14) begin
                add_frame($urandom_range(0, STORE_DEPTH - 1), 1'b1, 8'h00, END_BYTE, hold);
            end else if (pick < 24) begin
                add_frame(STORE_DEPTH, 1'b1, 8'h00, byte_t'($urandom_range(1, 255)), hold);
            end else begin
                add_frame(STORE_DEPTH, 1'b1, 8'h00, END_BYTE, hold);
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(rx_q.size() == 0 && !s_tvalid && chan_expect_q.size() == 0) &&
               cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (cycle_cnt >= CYCLE_LIMIT) begin
            fail_cnt++;
            $display("Timeout after %0d cycles with %0d bytes still queued.",
                     cycle_cnt, rx_q.size());
        end
        if (chan_expect_q.size() != 0) begin
            fail_cnt++;
            $display("%0d channel transactions never arrived.", chan_expect_q.size());
        end

        $display("Sent %0d bytes: %0d good frames, %0d dropped on a bad end byte, %0d cut short.",
                 bytes_sent, frames_good, frames_bad_end, frames_cut);
        $display("Checked %0d channel transactions, %0d failures.", results_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("** sbus_frame_channel_decoder: PASSED **");
        end else begin
            $display("** sbus_frame_channel_decoder: FAILED **");
        end
        $finish;
    end

endmodule
